FILE: hw/rtl/pcci_pkg.sv
// shared types, widths and helpers for the clamped-integral pid controller
package pcci_pkg;

  localparam int GAIN_W  = 24;
  localparam int DRIVE_W = 32;
  localparam int ERR_W   = DRIVE_W + 1;
  localparam int PROD_W  = GAIN_W + 1 + ERR_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int FRAC_W  = 16;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INT   = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_DRIVE_MIN  = 3'd3,
    REG_DRIVE_MAX  = 3'd4,
    REG_AUTOMATIC  = 3'd5,
    REG_REVERSE    = 3'd6
  } reg_idx_t;

  localparam logic CMD_COMPUTE = 1'b0;
  localparam logic CMD_RESUME  = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0]         gain_prop;
    logic [GAIN_W-1:0]         gain_int_per_sample;
    logic [GAIN_W-1:0]         gain_deriv_per_sample;
    logic signed [DRIVE_W-1:0] drive_min;
    logic signed [DRIVE_W-1:0] drive_max;
    logic                      automatic_cfg;
    logic                      reverse_acting;
  } cfg_t;

  typedef struct packed {
    logic                      cmd;
    logic signed [DRIVE_W-1:0] measurement;
    logic signed [DRIVE_W-1:0] target;
  } item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      updated;
  } res_t;

  // upper limit tested first, so an inverted pair resolves to the lower limit
  function automatic logic signed [DRIVE_W-1:0] clamp_drive(
    input logic signed [ACC_W-1:0]   v,
    input logic signed [DRIVE_W-1:0] lo,
    input logic signed [DRIVE_W-1:0] hi
  );
    logic signed [ACC_W-1:0] r;
    r = v;
    if (r > ACC_W'(hi)) r = ACC_W'(hi);
    if (r < ACC_W'(lo)) r = ACC_W'(lo);
    return r[DRIVE_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/pcci_cfg.sv
// configuration register file for the pid controller
module pcci_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [pcci_pkg::IDX_W-1:0] cfg_idx,
  input  logic [pcci_pkg::CFG_W-1:0] cfg_wdata,
  output pcci_pkg::cfg_t            cfg
);
  import pcci_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop             <= '0;
      cfg_r.gain_int_per_sample   <= '0;
      cfg_r.gain_deriv_per_sample <= '0;
      cfg_r.drive_min             <= '0;
      cfg_r.drive_max             <= {1'b0, {(DRIVE_W-1){1'b1}}};
      cfg_r.automatic_cfg         <= 1'b0;
      cfg_r.reverse_acting        <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_GAIN_PROP:  cfg_r.gain_prop             <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_INT:   cfg_r.gain_int_per_sample   <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_DERIV: cfg_r.gain_deriv_per_sample <= cfg_wdata[GAIN_W-1:0];
        REG_DRIVE_MIN:  cfg_r.drive_min             <= $signed(cfg_wdata[DRIVE_W-1:0]);
        REG_DRIVE_MAX:  cfg_r.drive_max             <= $signed(cfg_wdata[DRIVE_W-1:0]);
        REG_AUTOMATIC:  cfg_r.automatic_cfg         <= cfg_wdata[0];
        REG_REVERSE:    cfg_r.reverse_acting        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/pcci_datapath.sv
// pid math and controller state: integral, last measurement, held drive
module pcci_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  pcci_pkg::item_t item,
  input  pcci_pkg::cfg_t  cfg,
  output pcci_pkg::res_t  res
);
  import pcci_pkg::*;

  logic signed [DRIVE_W-1:0] integral_r, integral_nxt;
  logic signed [DRIVE_W-1:0] prev_meas_r, prev_meas_nxt;
  logic signed [DRIVE_W-1:0] held_r, held_nxt;

  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   dmeas;
  logic signed [GAIN_W:0]    gp_s, gi_s, gd_s;
  logic signed [PROD_W-1:0]  pprod, iprod, dprod;
  logic signed [ACC_W-1:0]   pterm, iterm, dterm;
  logic signed [ACC_W-1:0]   acc_int, acc_drv;
  logic signed [DRIVE_W-1:0] int_calc, drv_calc;
  logic                      upd;

  always_comb begin
    err   = ERR_W'(item.target) - ERR_W'(item.measurement);
    dmeas = ERR_W'(item.measurement) - ERR_W'(prev_meas_r);
    gp_s  = $signed({1'b0, cfg.gain_prop});
    gi_s  = $signed({1'b0, cfg.gain_int_per_sample});
    gd_s  = $signed({1'b0, cfg.gain_deriv_per_sample});
    pprod = gp_s * err;
    iprod = gi_s * err;
    dprod = gd_s * dmeas;
    // reverse acting flips the sign of all three terms
    pterm = cfg.reverse_acting ? -ACC_W'(pprod) : ACC_W'(pprod);
    iterm = cfg.reverse_acting ? -ACC_W'(iprod) : ACC_W'(iprod);
    dterm = cfg.reverse_acting ? -ACC_W'(dprod) : ACC_W'(dprod);

    acc_int  = (ACC_W'(integral_r) <<< FRAC_W) + iterm;
    int_calc = clamp_drive(acc_int >>> FRAC_W, cfg.drive_min, cfg.drive_max);
    acc_drv  = pterm + (ACC_W'(int_calc) <<< FRAC_W) - dterm;
    drv_calc = clamp_drive(acc_drv >>> FRAC_W, cfg.drive_min, cfg.drive_max);

    integral_nxt  = integral_r;
    prev_meas_nxt = prev_meas_r;
    held_nxt      = held_r;
    upd           = 1'b0;
    if (item.cmd == CMD_RESUME) begin
      // bumpless transfer
      integral_nxt  = clamp_drive(ACC_W'(held_r), cfg.drive_min, cfg.drive_max);
      prev_meas_nxt = item.measurement;
    end else if (cfg.automatic_cfg) begin
      integral_nxt  = int_calc;
      prev_meas_nxt = item.measurement;
      held_nxt      = drv_calc;
      upd           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r  <= '0;
      prev_meas_r <= '0;
      held_r      <= '0;
    end else if (step) begin
      integral_r  <= integral_nxt;
      prev_meas_r <= prev_meas_nxt;
      held_r      <= held_nxt;
    end
  end

  assign res.drive   = held_nxt;
  assign res.updated = upd;

endmodule

FILE: hw/rtl/pid_controller_clamped_integral_top.sv
// an accepted item waits in the input register, and its result is held in the output register
// throughput: one item per cycle unless the result side stalls, the single pass updates state on each step
// the output register holds a stalled result while the next item waits in the input register
// reset (rst_n low, synchronous) empties both registers and clears integral, last
// measurement and held drive; limits reset to 0 and 0x7fffffff, manual mode
module pid_controller_clamped_integral_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // input item
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [63:0]                in_tdata,   // [31:0] measurement, [63:32] target
  input  logic                       in_tuser,   // [0] cmd
  // result item
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,  // [31:0] drive
  output logic                       out_tuser,  // [0] updated
  // configuration writes
  input  logic                       cfg_we,
  input  logic [pcci_pkg::IDX_W-1:0] cfg_idx,
  input  logic [pcci_pkg::CFG_W-1:0] cfg_wdata
);
  import pcci_pkg::*;

  cfg_t  cfg;
  item_t in_item_r, in_item_nxt;
  logic  in_valid_r, in_valid_nxt;
  res_t  out_res_r, out_res_nxt;
  logic  out_valid_r, out_valid_nxt;
  res_t  res;
  logic  in_fire;
  logic  step;

  pcci_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // item moves from the input register into the result register when the latter frees up
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;
  assign in_fire   = in_tvalid && in_tready;

  pcci_datapath u_datapath (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_item_nxt  = in_item_r;
    if (in_fire) begin
      in_valid_nxt            = 1'b1;
      in_item_nxt.cmd         = in_tuser;
      in_item_nxt.measurement = $signed(in_tdata[31:0]);
      in_item_nxt.target      = $signed(in_tdata[63:32]);
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (step) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.drive;
  assign out_tuser  = out_res_r.updated;

  // a recomputed drive lies within the limits, or on the lower limit when they are inverted
  a_drive_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.updated |->
      (res.drive == cfg.drive_min) ||
      ((res.drive >= cfg.drive_min) && (res.drive <= cfg.drive_max)))
    else $error("recomputed drive outside limits");

  // every moved item shows up as a result next cycle
  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_tvalid)
    else $error("result missing after step");

  // an accepted item always lands in the input register
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_valid_r)
    else $error("accepted item lost");

endmodule

FILE: tb/tb_pid_controller_clamped_integral_top.sv
// self-checking testbench for the clamped-integral pid controller
`timescale 1ns / 100ps

module tb_pid_controller_clamped_integral_top;
  import pcci_pkg::*;

  localparam int  CLK_HALF      = 6;
  localparam int  RESET_CYCLES  = 7;
  localparam int  RANDOM_PHASES = 10;
  localparam int  PHASE_ITEMS   = 105;
  localparam int  QUIET_PHASES  = 2;       // last phases run without idling
  localparam int  TAIL_CYCLES   = 8;       // settling time after the last result is back
  localparam int  CYCLE_LIMIT   = 300000;

  localparam logic signed [DRIVE_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DRIVE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

  // ---------------------------------------------------------------------
  // expected-drive scoreboard: mirrors registers and controller state,
  // predicts one result per accepted item and checks results in order
  // ---------------------------------------------------------------------
  class drive_scoreboard;
    logic [GAIN_W-1:0]         kp, ki, kd;
    logic signed [DRIVE_W-1:0] lim_lo, lim_hi;
    logic                      auto_on, reverse_on;
    logic signed [DRIVE_W-1:0] integ, last_meas, held;
    res_t                      drive_q[$];
    int                        errors, n_checked, n_updated, n_resumes, n_writes;

    function new();
      kp = '0; ki = '0; kd = '0;
      lim_lo = '0; lim_hi = Q_MAX;
      auto_on = 1'b0; reverse_on = 1'b0;
      integ = '0; last_meas = '0; held = '0;
      errors = 0; n_checked = 0; n_updated = 0; n_resumes = 0; n_writes = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
      n_writes++;
      case (idx)
        REG_GAIN_PROP:  kp = v[GAIN_W-1:0];
        REG_GAIN_INT:   ki = v[GAIN_W-1:0];
        REG_GAIN_DERIV: kd = v[GAIN_W-1:0];
        REG_DRIVE_MIN:  lim_lo = v;
        REG_DRIVE_MAX:  lim_hi = v;
        REG_AUTOMATIC:  auto_on = v[0];
        REG_REVERSE:    reverse_on = v[0];
        default: ;
      endcase
    endfunction

    // upper limit first, so an inverted pair ends on the lower limit
    function logic signed [DRIVE_W-1:0] clamp_to_limits(longint v);
      longint r;
      r = v;
      if (r > longint'(lim_hi)) r = longint'(lim_hi);
      if (r < longint'(lim_lo)) r = longint'(lim_lo);
      return r[DRIVE_W-1:0];
    endfunction

    function void note_item(item_t it);
      longint err, dmeas, p_term, i_term, d_term, acc;
      res_t   r;
      r.updated = 1'b0;
      if (it.cmd == CMD_RESUME) begin
        n_resumes++;
        integ     = clamp_to_limits(longint'(held));
        last_meas = it.measurement;
      end else if (auto_on) begin
        err    = longint'(it.target) - longint'(it.measurement);
        dmeas  = longint'(it.measurement) - longint'(last_meas);
        p_term = longint'(kp) * err;
        i_term = longint'(ki) * err;
        d_term = longint'(kd) * dmeas;
        if (reverse_on) begin
          p_term = -p_term;
          i_term = -i_term;
          d_term = -d_term;
        end
        acc       = longint'(integ) * 65536 + i_term;
        integ     = clamp_to_limits(acc >>> FRAC_W);
        acc       = p_term + longint'(integ) * 65536 - d_term;
        held      = clamp_to_limits(acc >>> FRAC_W);
        last_meas = it.measurement;
        r.updated = 1'b1;
      end
      r.drive = held;
      drive_q.push_back(r);
    endfunction

    function void check_result(logic [DRIVE_W-1:0] drive, logic updated);
      res_t want;
      if (drive_q.size() == 0) begin
        errors++;
        $error("result with nothing expected: drive %h updated %b", drive, updated);
        return;
      end
      want = drive_q.pop_front();
      n_checked++;
      if (updated) n_updated++;
      if (drive !== want.drive) begin
        errors++;
        $error("drive mismatch: expected %h actual %h", want.drive, drive);
      end
      if (updated !== want.updated) begin
        errors++;
        $error("updated mismatch: expected %b actual %b", want.updated, updated);
      end
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // block under test
  // ---------------------------------------------------------------------
  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [63:0]        in_tdata;    // [31:0] measurement, [63:32] target
  logic               in_tuser;    // [0] cmd
  logic               out_tvalid;
  logic               out_tready;
  logic [31:0]        out_tdata;   // [31:0] drive
  logic               out_tuser;   // [0] updated
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_idx;
  logic [CFG_W-1:0]   cfg_wdata;

  pid_controller_clamped_integral_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  drive_scoreboard sb = new();

  int   cycles   = 0;
  int   items_in = 0;   // accepted input items, read by the driver at the falling edge
  logic idle_on  = 1'b1;
  logic signed [DRIVE_W-1:0] setpoint = '0;

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------
  // monitor: everything is sampled at the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      // results first: an item accepted now cannot produce one on this edge
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) begin
        sb.note_item('{cmd: in_tuser, measurement: in_tdata[31:0], target: in_tdata[63:32]});
        items_in <= items_in + 1;
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // result side back-pressure: random stall bursts while idling is enabled
  // ---------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = 1'b1;
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_tready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // driver tasks, all called and returning at a falling edge
  // ---------------------------------------------------------------------
  function automatic logic signed [DRIVE_W-1:0] q_int(int whole);
    return whole * 65536;
  endfunction

  // one register write, only issued while nothing is in flight
  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic write_limits(logic signed [DRIVE_W-1:0] lo, logic signed [DRIVE_W-1:0] hi);
    write_reg(REG_DRIVE_MIN, lo);
    write_reg(REG_DRIVE_MAX, hi);
  endtask

  task automatic write_gains(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] i,
                             logic [GAIN_W-1:0] d);
    write_reg(REG_GAIN_PROP,  CFG_W'(p));
    write_reg(REG_GAIN_INT,   CFG_W'(i));
    write_reg(REG_GAIN_DERIV, CFG_W'(d));
  endtask

  // offer one item, with an occasional idle burst in front of it
  task automatic send_item(logic cmd, logic signed [DRIVE_W-1:0] meas,
                           logic signed [DRIVE_W-1:0] tgt);
    int taken;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    taken     = items_in;
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {tgt, meas};
    do @(negedge clk); while (items_in == taken);
  endtask

  // stop sending until every expected result is back, then let the pipe settle
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // random stimulus helpers
  // ---------------------------------------------------------------------
  function automatic logic signed [DRIVE_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      default: return -1;
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, 24'h03_FFFF));  // up to about 4.0
    endcase
  endfunction

  task automatic randomize_config();
    logic signed [DRIVE_W-1:0] lo, hi, mag;
    case ($urandom_range(0, 5))
      0: begin
        lo = Q_MIN;
        hi = Q_MAX;
      end
      1: begin  // inverted pair
        mag = $urandom_range(0, 32'h0100_0000);
        lo  = mag;
        hi  = -mag;
      end
      2: begin  // anything, ordered or not
        lo = $urandom;
        hi = $urandom;
      end
      default: begin
        mag = $urandom_range(32'h0001_0000, 32'h0200_0000);
        lo  = -mag;
        hi  = mag;
      end
    endcase
    write_gains(pick_gain(), pick_gain(), pick_gain());
    write_limits(lo, hi);
    write_reg(REG_AUTOMATIC, CFG_W'($urandom_range(0, 4) != 0));
    write_reg(REG_REVERSE,   CFG_W'($urandom_range(0, 1)));
  endtask

  // mostly a measurement wandering around a slowly moving setpoint,
  // with some full-range noise and some extremes mixed in
  task automatic send_random_item();
    logic                      cmd;
    logic signed [DRIVE_W-1:0] meas, tgt;
    cmd = ($urandom_range(0, 11) == 0) ? CMD_RESUME : CMD_COMPUTE;
    if ($urandom_range(0, 19) == 0)
      setpoint = int'($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000;
    case ($urandom_range(0, 9))
      0: begin
        meas = $urandom;
        tgt  = $urandom;
      end
      1: begin
        meas = pick_extreme();
        tgt  = pick_extreme();
      end
      default: begin
        tgt  = setpoint;
        meas = setpoint + (int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      end
    endcase
    send_item(cmd, meas, tgt);
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_COMPUTE;
    cfg_we    = 1'b0;
    cfg_idx   = REG_GAIN_PROP;
    cfg_wdata = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings are manual mode: a compute just holds, a resume loads state
    send_item(CMD_COMPUTE, Q_MAX, Q_MIN);
    send_item(CMD_RESUME, 32'sh1234_5678, '0);
    drain();

    // plain automatic operation with moderate gains and limits
    write_gains(24'h01_0000, 24'h00_8000, 24'h00_4000);
    write_limits(q_int(-100), q_int(100));
    write_reg(REG_AUTOMATIC, 1);
    write_reg(REG_REVERSE, 0);
    send_item(CMD_COMPUTE, '0, q_int(10));
    send_item(CMD_COMPUTE, q_int(2), q_int(10));
    send_item(CMD_COMPUTE, Q_MAX, Q_MIN);
    send_item(CMD_COMPUTE, Q_MIN, Q_MAX);
    send_item(CMD_COMPUTE, q_int(5), q_int(5));
    send_item(CMD_RESUME, q_int(3), '0);      // resume while in automatic mode
    send_item(CMD_COMPUTE, q_int(3), q_int(4));
    drain();

    // largest gains and full-range limits: widest sums
    write_gains('1, '1, '1);
    write_limits(Q_MIN, Q_MAX);
    send_item(CMD_COMPUTE, Q_MIN, Q_MAX);
    send_item(CMD_COMPUTE, Q_MAX, Q_MIN);
    send_item(CMD_COMPUTE, '0, '0);
    send_item(CMD_COMPUTE, -1, -1);
    drain();

    // reverse acting negates all three terms
    write_gains(24'h02_0000, 24'h02_0000, 24'h02_0000);
    write_limits(q_int(-100), q_int(100));
    write_reg(REG_REVERSE, 1);
    send_item(CMD_COMPUTE, '0, q_int(10));
    send_item(CMD_COMPUTE, q_int(1), q_int(10));
    send_item(CMD_COMPUTE, q_int(-3), q_int(-20));
    drain();

    // inverted limits: the lower limit wins
    write_limits(q_int(50), q_int(-50));
    send_item(CMD_COMPUTE, '0, q_int(1));
    send_item(CMD_RESUME, q_int(2), '0);
    drain();

    // saturate the drive, then narrow the limits: state is not clamped by the write
    write_reg(REG_REVERSE, 0);
    write_limits(q_int(-100), q_int(100));
    send_item(CMD_COMPUTE, '0, q_int(100));
    drain();
    write_limits(q_int(-1), q_int(1));
    write_reg(REG_AUTOMATIC, 0);
    send_item(CMD_COMPUTE, q_int(7), q_int(8));   // manual: old held drive comes back
    send_item(CMD_RESUME, q_int(7), '0);          // integral takes the clamped held drive
    drain();
    write_reg(REG_AUTOMATIC, 1);
    send_item(CMD_COMPUTE, q_int(7), q_int(7));
    drain();

    // random phases, each with fresh settings; the last ones run without idling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_on = (ph < RANDOM_PHASES - QUIET_PHASES);
      randomize_config();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_item();
        if (idle_on && $urandom_range(0, 49) == 0)
          drain();
      end
      drain();
    end

    $display("checked %0d results (%0d recomputed, %0d resumes) over %0d register writes",
             sb.n_checked, sb.n_updated, sb.n_resumes, sb.n_writes);
    $display("directed extremes, inverted limits, manual hold and %0d random phases, %0d cycles",
             RANDOM_PHASES, cycles);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
